/* rtl/dcc_pkg.sv */
`timescale 1ns / 1ps

package dcc_pkg;

    localparam int COORD_W    = 14;
    localparam int IDX_W      = 12;
    localparam int CFG_W      = 7;
    localparam int OUT_CNT_W  = 13;
    localparam int CMP_W      = 17;

    localparam logic [CFG_W-1:0] SIDE_RESET = 7'd40;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DISK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_BASE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

/* rtl/disk_coverage_counter_unit.sv */
`timescale 1ns / 1ps

// channel   dir  handshake                  payload
// in        in   i_in_valid / o_in_stall    i_kind .. i_decrement
// out       out  o_out_valid / i_out_stall  o_covered_count, o_counter_fault
// cfg       in   i_cfg_we                   i_cfg_data (cells per side)
//
// load request: point store written on the accepting edge
// disk request: one cell per cycle of the clamped box through the counter memory read,
//   square, compare and write-back pipeline; an empty box skips the walk
// after reset the counter memory is zeroed while the input is stalled
// a finished result waits in the output register while the next request is taken

module disk_coverage_counter_unit #(
    parameter int MAX_SIDE    = 64,
    parameter int FRAC_BITS   = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dcc_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_kind,
    input  logic [dcc_pkg::IDX_W-1:0]    i_point_index,
    input  logic [dcc_pkg::COORD_W-1:0]  i_point_x,
    input  logic [dcc_pkg::COORD_W-1:0]  i_point_y,
    input  logic [dcc_pkg::COORD_W-1:0]  i_center_x,
    input  logic [dcc_pkg::COORD_W-1:0]  i_center_y,
    input  logic [dcc_pkg::COORD_W-1:0]  i_radius,
    input  logic                         i_layer,
    input  logic                         i_decrement,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [dcc_pkg::OUT_CNT_W-1:0] o_covered_count,
    output logic                         o_counter_fault
);

    import dcc_pkg::*;

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;
    localparam int CELL_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int SQ_W   = 2 * COORD_W;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]   r_grid_side;
    logic [SIDE_W-1:0]  side_eff;

    logic               in_accept;
    logic               walk_issue;
    logic               out_load;
    logic               cover_ready;
    logic               load_wr;

    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic [COORD_W-1:0] r_rad;
    logic               r_layer;
    logic               r_dec;
    logic [SQ_W-1:0]    r_r2;

    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W:0]   hi_x;
    logic [COORD_W:0]   hi_y;
    logic [CMP_W-1:0]   side_m1;
    logic [CMP_W-1:0]   x1_cmp;
    logic [CMP_W-1:0]   y1_cmp;
    logic               box_empty;

    logic [CELL_W-1:0]  r_x0;
    logic [CELL_W-1:0]  r_x1;
    logic [CELL_W-1:0]  r_y0;
    logic [CELL_W-1:0]  r_y1;
    logic [CELL_W-1:0]  r_ix;
    logic [CELL_W-1:0]  r_iy;
    logic [ADDR_W-1:0]  r_base;
    logic [CELL_W+SIDE_W-1:0] base_prod;
    logic [ADDR_W-1:0]  issue_addr;
    logic               walk_last;

    logic [2*COORD_W-1:0] r_pt_mem [DEPTH];
    logic [2*COORD_W-1:0] r_pt_rd;

    logic                   r_s1_valid;
    logic [ADDR_W-1:0]      r_s1_addr;
    logic [COUNT_WIDTH-1:0] rd_act;
    logic [COUNT_WIDTH-1:0] rd_rem;
    logic [COORD_W-1:0]     pt_x;
    logic [COORD_W-1:0]     pt_y;

    logic                   r_s2_valid;
    logic [ADDR_W-1:0]      r_s2_addr;
    logic [COORD_W-1:0]     r_s2_dx;
    logic [COORD_W-1:0]     r_s2_dy;
    logic [COUNT_WIDTH-1:0] r_s2_act;
    logic [COUNT_WIDTH-1:0] r_s2_rem;

    logic                   r_s3_valid;
    logic [ADDR_W-1:0]      r_s3_addr;
    logic [SQ_W-1:0]        r_s3_dx2;
    logic [SQ_W-1:0]        r_s3_dy2;
    logic [COUNT_WIDTH-1:0] r_s3_act;
    logic [COUNT_WIDTH-1:0] r_s3_rem;

    logic [SQ_W:0]          dist2;
    logic                   in_disk;
    logic [COUNT_WIDTH-1:0] cur;
    logic                   at_lim;
    logic [COUNT_WIDTH-1:0] upd;
    logic [COUNT_WIDTH-1:0] new_act;
    logic [COUNT_WIDTH-1:0] new_rem;
    logic                   was_cov;
    logic                   now_cov;
    logic                   cnt_wr;

    logic [TOT_W-1:0]       r_total;
    logic                   r_fault;
    logic [OUT_CNT_W-1:0]   r_out_count;
    logic                   r_out_fault;
    logic                   r_out_valid;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= SIDE_RESET;
        end else if (i_cfg_we) begin
            r_grid_side <= i_cfg_data;
        end
    end

    assign side_eff = (CMP_W'(r_grid_side) > CMP_W'(MAX_SIDE)) ?
                      SIDE_W'(MAX_SIDE) : SIDE_W'(r_grid_side);

    assign o_in_stall = !((r_state == ST_IDLE) && cover_ready);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign load_wr    = in_accept && (i_kind == KIND_LOAD) &&
                        ((CMP_W'(i_point_index)) < CMP_W'(DEPTH));

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_rad   <= i_radius;
            r_layer <= i_layer;
            r_dec   <= i_decrement;
        end
    end

    // clamped bounding box
    assign lo_x = (r_cx < r_rad) ? '0 : (r_cx - r_rad) >> FRAC_BITS;
    assign lo_y = (r_cy < r_rad) ? '0 : (r_cy - r_rad) >> FRAC_BITS;
    assign hi_x = ({1'b0, r_cx} + {1'b0, r_rad}) >> FRAC_BITS;
    assign hi_y = ({1'b0, r_cy} + {1'b0, r_rad}) >> FRAC_BITS;
    assign side_m1 = CMP_W'(side_eff) - CMP_W'(1);
    assign x1_cmp  = (CMP_W'(hi_x) > side_m1) ? side_m1 : CMP_W'(hi_x);
    assign y1_cmp  = (CMP_W'(hi_y) > side_m1) ? side_m1 : CMP_W'(hi_y);
    assign box_empty = (side_eff == '0) || (CMP_W'(lo_x) > x1_cmp) ||
                       (CMP_W'(lo_y) > y1_cmp);

    assign base_prod  = r_y0 * side_eff;
    assign issue_addr = r_base + ADDR_W'(r_ix);
    assign walk_last  = (r_ix == r_x1) && (r_iy == r_y1);

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_BOX: begin
                r_x0 <= lo_x[CELL_W-1:0];
                r_y0 <= lo_y[CELL_W-1:0];
                r_x1 <= x1_cmp[CELL_W-1:0];
                r_y1 <= y1_cmp[CELL_W-1:0];
                r_r2 <= r_rad * r_rad;
            end
            ST_BASE: begin
                r_base <= base_prod[ADDR_W-1:0];
                r_ix   <= r_x0;
                r_iy   <= r_y0;
            end
            ST_WALK: begin
                if (r_ix == r_x1) begin
                    r_ix   <= r_x0;
                    r_iy   <= r_iy + CELL_W'(1);
                    r_base <= r_base + ADDR_W'(side_eff);
                end else begin
                    r_ix <= r_ix + CELL_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_pt_mem[ADDR_W'(i_point_index)] <= {i_point_x, i_point_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_issue) begin
            r_pt_rd <= r_pt_mem[issue_addr];
        end
    end

    assign pt_x = r_pt_rd[2*COORD_W-1:COORD_W];
    assign pt_y = r_pt_rd[COORD_W-1:0];

    dcc_cover_store #(
        .MAX_SIDE    (MAX_SIDE),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_cover_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (walk_issue),
        .i_rd_addr (issue_addr),
        .o_rd_act  (rd_act),
        .o_rd_rem  (rd_rem),
        .i_wr_en   (cnt_wr),
        .i_wr_addr (r_s3_addr),
        .i_wr_act  (new_act),
        .i_wr_rem  (new_rem),
        .o_ready   (cover_ready)
    );

    // cell pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= walk_issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= issue_addr;
        r_s2_addr <= r_s1_addr;
        r_s2_dx   <= (pt_x >= r_cx) ? pt_x - r_cx : r_cx - pt_x;
        r_s2_dy   <= (pt_y >= r_cy) ? pt_y - r_cy : r_cy - pt_y;
        r_s2_act  <= rd_act;
        r_s2_rem  <= rd_rem;
        r_s3_addr <= r_s2_addr;
        r_s3_dx2  <= r_s2_dx * r_s2_dx;
        r_s3_dy2  <= r_s2_dy * r_s2_dy;
        r_s3_act  <= r_s2_act;
        r_s3_rem  <= r_s2_rem;
    end

    // compare and counter update
    assign dist2   = {1'b0, r_s3_dx2} + {1'b0, r_s3_dy2};
    assign in_disk = dist2 <= {1'b0, r_r2};
    assign cur     = r_layer ? r_s3_act : r_s3_rem;
    assign at_lim  = r_dec ? (cur == '0) : (cur == '1);
    assign upd     = r_dec ? cur - COUNT_WIDTH'(1) : cur + COUNT_WIDTH'(1);
    assign new_act = (r_layer && !at_lim) ? upd : r_s3_act;
    assign new_rem = (!r_layer && !at_lim) ? upd : r_s3_rem;
    assign was_cov = (r_s3_act != '0) && (r_s3_rem == '0);
    assign now_cov = (new_act != '0) && (new_rem == '0);
    assign cnt_wr  = r_s3_valid && in_disk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_fault <= 1'b0;
        end else begin
            if (in_accept) begin
                r_fault <= 1'b0;
            end else if (cnt_wr && at_lim) begin
                r_fault <= 1'b1;
            end
            if (cnt_wr && now_cov && !was_cov) begin
                r_total <= r_total + TOT_W'(1);
            end else if (cnt_wr && was_cov && !now_cov) begin
                r_total <= r_total - TOT_W'(1);
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        walk_issue = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_kind == KIND_DISK) ? ST_BOX : ST_DONE;
                end
            end
            ST_BOX: begin
                n_state = box_empty ? ST_DONE : ST_BASE;
            end
            ST_BASE: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                walk_issue = 1'b1;
                if (walk_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!(r_s1_valid || r_s2_valid || r_s3_valid)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count <= OUT_CNT_W'(32'(r_total));
            r_out_fault <= r_fault;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_covered_count = r_out_count;
    assign o_counter_fault = r_out_fault;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(r_s1_valid || r_s2_valid || r_s3_valid))
        else $error("cell pipeline busy while idle");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside done state");

    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> cover_ready)
        else $error("counter update during clear sweep");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= 32'(DEPTH))
        else $error("covered total above point count");

    a_walk_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_issue |-> ((r_ix <= r_x1) && (r_iy <= r_y1)))
        else $error("walk left its box");

endmodule

/* rtl/dcc_cover_store.sv */
`timescale 1ns / 1ps

module dcc_cover_store #(
    parameter int MAX_SIDE    = 64,
    parameter int COUNT_WIDTH = 16,
    parameter int ADDR_W      = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    output logic [COUNT_WIDTH-1:0] o_rd_act,
    output logic [COUNT_WIDTH-1:0] o_rd_rem,
    input  logic                   i_wr_en,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    input  logic [COUNT_WIDTH-1:0] i_wr_act,
    input  logic [COUNT_WIDTH-1:0] i_wr_rem,
    output logic                   o_ready
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    logic [2*COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [2*COUNT_WIDTH-1:0] r_rd_data;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic                     r_clearing;

    // zero sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_act, i_wr_rem};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_act = r_rd_data[2*COUNT_WIDTH-1:COUNT_WIDTH];
    assign o_rd_rem = r_rd_data[COUNT_WIDTH-1:0];
    assign o_ready  = !r_clearing;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import dcc_pkg::*;

    localparam int MAX_SIDE    = 64;
    localparam int FRAC_BITS   = 8;
    localparam int CELL        = 1 << FRAC_BITS;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int COUNT_MAX   = 65535;
    localparam int BOX_LIMIT   = 300;

    localparam logic LAYER_ACTIVE  = 1'b1;
    localparam logic LAYER_REMOVAL = 1'b0;
    localparam logic DIR_ADD       = 1'b0;
    localparam logic DIR_REMOVE    = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   index;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] radius;
        logic               layer;
        logic               dec;
    } t_disk_req;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] covered;
        logic                 fault;
    } t_coverage;

    class coverage_scoreboard;
        int        pt_x[STORE_DEPTH];
        int        pt_y[STORE_DEPTH];
        bit        written[STORE_DEPTH];
        int        active_cnt[STORE_DEPTH];
        int        removal_cnt[STORE_DEPTH];
        int        covered_total;
        int        side_reg;
        int        errors;
        int        checked;
        t_coverage expected_totals[$];

        function new();
            side_reg = SIDE_RESET;
            covered_total = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int grid_in_use();
            return (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
        endfunction

        // clamped cell box of a disk, empty box returns 0
        function bit clamp_box(input int cx, input int cy, input int r,
                               output int x0, output int x1, output int y0, output int y1);
            int n;
            n = grid_in_use();
            x0 = (cx < r) ? 0 : (cx - r) >> FRAC_BITS;
            y0 = (cy < r) ? 0 : (cy - r) >> FRAC_BITS;
            x1 = (cx + r) >> FRAC_BITS;
            y1 = (cy + r) >> FRAC_BITS;
            if (x1 > n - 1) x1 = n - 1;
            if (y1 > n - 1) y1 = n - 1;
            return n != 0 && x0 <= x1 && y0 <= y1;
        endfunction

        function bit walk_disk(t_disk_req r);
            int     x0, x1, y0, y1, n, q, cnt;
            longint dx, dy, r2;
            bit     was, now, fault;
            fault = 1'b0;
            if (!clamp_box(r.cx, r.cy, r.radius, x0, x1, y0, y1))
                return 1'b0;
            n = grid_in_use();
            r2 = longint'(r.radius) * longint'(r.radius);
            for (int iy = y0; iy <= y1; iy++) begin
                for (int ix = x0; ix <= x1; ix++) begin
                    q = iy * n + ix;
                    dx = longint'(pt_x[q]) - longint'(r.cx);
                    dy = longint'(pt_y[q]) - longint'(r.cy);
                    if (dx * dx + dy * dy <= r2) begin
                        was = active_cnt[q] > 0 && removal_cnt[q] == 0;
                        cnt = (r.layer == LAYER_ACTIVE) ? active_cnt[q] : removal_cnt[q];
                        if (r.dec == DIR_REMOVE) begin
                            if (cnt == 0) fault = 1'b1;
                            else cnt--;
                        end else begin
                            if (cnt >= COUNT_MAX) fault = 1'b1;
                            else cnt++;
                        end
                        if (r.layer == LAYER_ACTIVE) active_cnt[q] = cnt;
                        else removal_cnt[q] = cnt;
                        now = active_cnt[q] > 0 && removal_cnt[q] == 0;
                        if (now && !was) covered_total++;
                        if (was && !now) covered_total--;
                    end
                end
            end
            return fault;
        endfunction

        function void note_request(t_disk_req r);
            t_coverage e;
            e.fault = 1'b0;
            if (r.kind == KIND_LOAD) begin
                if (r.index < STORE_DEPTH) begin
                    pt_x[r.index] = r.px;
                    pt_y[r.index] = r.py;
                    written[r.index] = 1'b1;
                end
            end else begin
                e.fault = walk_disk(r);
            end
            e.covered = OUT_CNT_W'(covered_total);
            expected_totals.insert(expected_totals.size(), e);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("result %0d: %s, got %0d, want %0d", checked, what, got, want);
        endtask

        task check_result(logic [OUT_CNT_W-1:0] covered, logic fault);
            t_coverage e;
            if (expected_totals.size() == 0) begin
                report_mismatch("result with no pending request", covered, 0);
            end else begin
                e = expected_totals.pop_front();
                if (covered !== e.covered)
                    report_mismatch("covered_count", covered, e.covered);
                if (fault !== e.fault)
                    report_mismatch("counter_fault", fault, e.fault);
            end
            checked++;
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_data = SIDE_RESET;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               kind = KIND_LOAD;
    logic [IDX_W-1:0]   point_index = '0;
    logic [COORD_W-1:0] point_x = '0;
    logic [COORD_W-1:0] point_y = '0;
    logic [COORD_W-1:0] center_x = '0;
    logic [COORD_W-1:0] center_y = '0;
    logic [COORD_W-1:0] radius = '0;
    logic               layer = LAYER_ACTIVE;
    logic               decrement = DIR_ADD;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [OUT_CNT_W-1:0] covered_count;
    logic               counter_fault;

    logic steady = 1'b0;
    logic hold_request = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;
    int   items_sent = 0;

    coverage_scoreboard sb = new();
    t_disk_req placed_disks[$];

    disk_coverage_counter_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_kind          (kind),
        .i_point_index   (point_index),
        .i_point_x       (point_x),
        .i_point_y       (point_y),
        .i_center_x      (center_x),
        .i_center_y      (center_y),
        .i_radius        (radius),
        .i_layer         (layer),
        .i_decrement     (decrement),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_covered_count (covered_count),
        .o_counter_fault (counter_fault)
    );

    always #2 clk = ~clk;

    // result check and receiver stall, with one long hold-off
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(covered_count, counter_fault);
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else begin
            out_stall <= !steady && ($urandom_range(0, 99) < 38);
        end
    end

    function automatic t_disk_req random_fields();
        t_disk_req r;
        r.kind   = 1'($urandom_range(0, 1));
        r.index  = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
        r.px     = COORD_W'($urandom_range(0, 16383));
        r.py     = COORD_W'($urandom_range(0, 16383));
        r.cx     = COORD_W'($urandom_range(0, 16383));
        r.cy     = COORD_W'($urandom_range(0, 16383));
        r.radius = COORD_W'($urandom_range(0, 16383));
        r.layer  = 1'($urandom_range(0, 1));
        r.dec    = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic send_request(input t_disk_req r);
        while (!steady && $urandom_range(0, 99) < 38) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= r.kind;
        point_index <= r.index;
        point_x     <= r.px;
        point_y     <= r.py;
        center_x    <= r.cx;
        center_y    <= r.cy;
        radius      <= r.radius;
        layer       <= r.layer;
        decrement   <= r.dec;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic load_point(input int idx, input int x, input int y);
        t_disk_req r;
        r = random_fields();
        r.kind  = KIND_LOAD;
        r.index = IDX_W'(idx);
        r.px    = COORD_W'(x);
        r.py    = COORD_W'(y);
        send_request(r);
    endtask

    // shrinks oversized disks, loads every not yet written point the box reaches, then sends
    task automatic send_disk(input t_disk_req r, input bit remember);
        int x0, x1, y0, y1, n;
        r.kind = KIND_DISK;
        while (sb.clamp_box(r.cx, r.cy, r.radius, x0, x1, y0, y1)
               && (x1 - x0 + 1) * (y1 - y0 + 1) > BOX_LIMIT)
            r.radius = r.radius >> 1;
        n = sb.grid_in_use();
        for (int iy = y0; iy <= y1; iy++) begin
            for (int ix = x0; ix <= x1; ix++) begin
                if (!sb.written[iy * n + ix])
                    load_point(iy * n + ix, ix * CELL + $urandom_range(0, CELL - 1),
                               iy * CELL + $urandom_range(0, CELL - 1));
            end
        end
        if (remember) begin
            placed_disks.insert(placed_disks.size(), r);
            if (placed_disks.size() > 48) void'(placed_disks.pop_front());
        end
        send_request(r);
    endtask

    task automatic place_disk(input int cx, input int cy, input int rad,
                              input logic lyr, input logic dir);
        t_disk_req r;
        r = random_fields();
        r.cx     = COORD_W'(cx);
        r.cy     = COORD_W'(cy);
        r.radius = COORD_W'(rad);
        r.layer  = lyr;
        r.dec    = dir;
        send_disk(r, 1'b0);
    endtask

    task automatic set_side(input int side);
        in_valid <= 1'b0;
        while (sb.expected_totals.size() != 0) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= CFG_W'(side);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.side_reg = side;
    endtask

    task automatic random_phase(input int side, input int count);
        t_disk_req r;
        int stop, pick, n, k;
        set_side(side);
        stop = items_sent + count;
        n = sb.grid_in_use();
        while (items_sent < stop) begin
            r = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                r.kind = KIND_LOAD;
                send_request(r);
            end else if (pick < 35 && placed_disks.size() != 0) begin
                k = $urandom_range(0, placed_disks.size() - 1);
                r = placed_disks[k];
                placed_disks.delete(k);
                r.dec = DIR_REMOVE;
                send_disk(r, 1'b0);
            end else if (pick < 45) begin
                send_disk(r, 1'b0);
            end else begin
                r.cx = COORD_W'($urandom_range(0, n * CELL - 1));
                r.cy = COORD_W'($urandom_range(0, n * CELL - 1));
                if ($urandom_range(0, 99) < 80) r.radius = COORD_W'($urandom_range(0, 700));
                r.layer = ($urandom_range(0, 99) < 70) ? LAYER_ACTIVE : LAYER_REMOVAL;
                r.dec = DIR_ADD;
                send_disk(r, 1'b1);
            end
        end
    endtask

    initial begin
        int sides[7];
        sides = '{64, 8, 127, 40, 3, 17, 64};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset side, single point corner cases
        load_point(0, 128, 128);
        place_disk(128, 128, 0, LAYER_ACTIVE, DIR_REMOVE);
        place_disk(128, 128, 0, LAYER_ACTIVE, DIR_ADD);
        place_disk(128, 128, 0, LAYER_REMOVAL, DIR_ADD);
        place_disk(128, 128, 0, LAYER_REMOVAL, DIR_REMOVE);
        load_point(STORE_DEPTH - 1, 16383, 16383);
        load_point(1, 0, 0);
        place_disk(16383, 16383, 0, LAYER_ACTIVE, DIR_ADD);
        place_disk(0, 0, 0, LAYER_ACTIVE, DIR_ADD);
        place_disk(0, 0, 200, LAYER_ACTIVE, DIR_ADD);

        // zero side, disks update nothing
        set_side(0);
        place_disk(0, 0, 16383, LAYER_ACTIVE, DIR_ADD);
        place_disk(300, 300, 16383, LAYER_REMOVAL, DIR_REMOVE);
        load_point(2, 300, 50);

        set_side(2);
        place_disk(256, 256, 16383, LAYER_ACTIVE, DIR_ADD);
        place_disk(256, 256, 16383, LAYER_REMOVAL, DIR_REMOVE);

        // one cell grid, back to back disks on point 0
        set_side(1);
        steady <= 1'b1;
        repeat (40)
            place_disk(sb.pt_x[0], sb.pt_y[0], 0, LAYER_ACTIVE, DIR_ADD);
        place_disk(sb.pt_x[0], sb.pt_y[0], 0, LAYER_ACTIVE, DIR_REMOVE);
        in_valid <= 1'b0;
        steady <= 1'b0;

        foreach (sides[i]) begin
            if (i == 2) hold_request <= 1'b1;
            random_phase(sides[i], 185);
        end

        in_valid <= 1'b0;
        while (sb.expected_totals.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
